// ===== rtl/run_length_bounded_stack_top_defines.svh =====
`ifndef RUN_LENGTH_BOUNDED_STACK_TOP_DEFINES_SVH
`define RUN_LENGTH_BOUNDED_STACK_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RLBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RLBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rlbs_pkg.sv =====
`default_nettype none

package rlbs_pkg;

  localparam int unsigned RUN_DEPTH  = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(RUN_DEPTH);
  localparam int unsigned PTR_W      = $clog2(RUN_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_TOP  = 2'd2,
    MODE_SIZE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_TOP  = 2'd1,
    SEL_SIZE = 2'd2
  } data_sel_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_POP  = 2'd2,
    S_RESP = 2'd3
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] count;
    logic [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        data_valid;
    logic [31:0] data_out;
  } out_item_t;

  typedef struct packed {
    logic      load;       // capture the accepted item
    logic      push;       // store a new run
    logic      pop_start;  // take count off the total
    logic      pop_run;    // drop the whole top run
    logic      trim;       // shorten the top run
    logic      set_err;
    logic      out_load;
    status_e   status;
    data_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic  err;
    mode_e mode;
    logic  count_zero;
    logic  push_over;
    logic  ptr_full;
    logic  ptr_empty;
    logic  pop_under;
    logic  run_covers;  // remaining count covers the whole top run
    logic  run_exact;   // remaining count ends exactly on the top run
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rlbs_dp.sv =====
`default_nettype none

module rlbs_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rlbs_pkg::in_item_t in_item_i,
  input  logic               cfg_valid_i,
  input  logic [31:0]        cfg_data_i,
  input  rlbs_pkg::dp_cmd_t  cmd_i,
  output rlbs_pkg::dp_stat_t stat_o,
  output rlbs_pkg::out_item_t out_item_o
);
  import rlbs_pkg::*;

  logic [31:0]           cnt_mem [RUN_DEPTH];
  logic [DATA_WIDTH-1:0] val_mem [RUN_DEPTH];

  mode_e                 mode_q;
  logic [31:0]           rem_q, rem_d;
  logic [DATA_WIDTH-1:0] value_q;
  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic [31:0]           total_q, total_d;
  logic [31:0]           cap_q;
  logic                  err_q;
  logic [31:0]           cnt_rd_q;
  logic [DATA_WIDTH-1:0] val_rd_q;
  out_item_t             out_q;

  logic [IDX_W-1:0]      top_idx, rd_idx, wr_idx;
  logic [32:0]           push_sum;
  logic                  cnt_we;
  logic [31:0]           cnt_wdata;
  logic [63:0]           val_ext, in_val_ext;

  assign top_idx  = IDX_W'(ptr_q - PTR_W'(1));
  assign rd_idx   = IDX_W'(ptr_d - PTR_W'(1));
  assign push_sum = {1'b0, total_q} + {1'b0, rem_q};
  assign val_ext    = 64'(val_rd_q);
  assign in_val_ext = 64'(in_item_i.item_value);

  always_comb begin
    ptr_d   = ptr_q;
    total_d = total_q;
    rem_d   = rem_q;
    if (cmd_i.push) begin
      ptr_d   = ptr_q + PTR_W'(1);
      total_d = total_q + rem_q;
    end
    if (cmd_i.pop_start) begin
      total_d = total_q - rem_q;
    end
    if (cmd_i.pop_run) begin
      ptr_d = ptr_q - PTR_W'(1);
      rem_d = rem_q - cnt_rd_q;
    end
    if (cmd_i.trim) begin
      rem_d = '0;
    end
  end

  // single write port: new run at the pointer, or trim of the top run
  assign cnt_we    = cmd_i.push | cmd_i.trim;
  assign wr_idx    = cmd_i.push ? IDX_W'(ptr_q) : top_idx;
  assign cnt_wdata = cmd_i.push ? rem_q : (cnt_rd_q - rem_q);

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[wr_idx] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      val_mem[wr_idx] <= value_q;
    end
    val_rd_q <= val_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      total_q <= '0;
      cap_q   <= '1;
      err_q   <= 1'b0;
    end else begin
      ptr_q   <= ptr_d;
      total_q <= total_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= in_item_i.mode;
      rem_q   <= in_item_i.count;
      value_q <= in_val_ext[DATA_WIDTH-1:0];
    end else begin
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) begin
      out_q.status <= cmd_i.status;
      unique case (cmd_i.sel)
        SEL_TOP: begin
          out_q.data_valid <= 1'b1;
          out_q.data_out   <= val_ext[31:0];
        end
        SEL_SIZE: begin
          out_q.data_valid <= 1'b1;
          out_q.data_out   <= total_q;
        end
        default: begin
          out_q.data_valid <= 1'b0;
          out_q.data_out   <= '0;
        end
      endcase
    end
  end

  assign stat_o.err        = err_q;
  assign stat_o.mode       = mode_q;
  assign stat_o.count_zero = (rem_q == '0);
  assign stat_o.push_over  = (push_sum > {1'b0, cap_q});
  assign stat_o.ptr_full   = (ptr_q == PTR_W'(RUN_DEPTH));
  assign stat_o.ptr_empty  = (ptr_q == '0);
  assign stat_o.pop_under  = (rem_q > total_q);
  assign stat_o.run_covers = (rem_q >= cnt_rd_q);
  assign stat_o.run_exact  = (rem_q == cnt_rd_q);

  assign out_item_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/rlbs_ctrl.sv =====
`default_nettype none

module rlbs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rlbs_pkg::dp_stat_t stat_i,
  output rlbs_pkg::dp_cmd_t  cmd_o
);
  import rlbs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = ST_OK;
    cmd_o.sel    = SEL_NONE;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end

      // nothing changes until the output register can take the result
      S_EXEC: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
          if (stat_i.err) begin
            cmd_o.status = ST_IGNORED;
          end else begin
            unique case (stat_i.mode)
              MODE_PUSH: begin
                if (stat_i.push_over) begin
                  cmd_o.set_err = 1'b1;
                  cmd_o.status  = ST_FULL;
                end else if (stat_i.count_zero) begin
                  cmd_o.status = ST_OK;
                end else if (stat_i.ptr_full) begin
                  cmd_o.set_err = 1'b1;
                  cmd_o.status  = ST_FULL;
                end else begin
                  cmd_o.push = 1'b1;
                end
              end
              MODE_POP: begin
                if (stat_i.pop_under) begin
                  cmd_o.set_err = 1'b1;
                  cmd_o.status  = ST_EMPTY;
                end else if (!stat_i.count_zero) begin
                  cmd_o.out_load  = 1'b0;
                  cmd_o.pop_start = 1'b1;
                  state_d         = S_POP;
                end
              end
              MODE_TOP: begin
                if (stat_i.ptr_empty) begin
                  cmd_o.set_err = 1'b1;
                  cmd_o.status  = ST_EMPTY;
                end else begin
                  cmd_o.sel = SEL_TOP;
                end
              end
              default: begin
                cmd_o.sel = SEL_SIZE;
              end
            endcase
          end
        end
      end

      // one run per cycle; the read port already shows the next top run
      S_POP: begin
        if (stat_i.ptr_empty) begin
          state_d = S_RESP;
        end else if (stat_i.run_covers) begin
          cmd_o.pop_run = 1'b1;
          if (stat_i.run_exact) begin
            state_d = S_RESP;
          end
        end else begin
          cmd_o.trim = 1'b1;
          state_d    = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/run_length_bounded_stack_top.sv =====
// Run-length stack: elements are held as (count, value) runs in a 64-entry run
// memory, with the total bounded by the capacity register (reset all ones,
// written over the cfg channel, always ready). One item is worked at a time.
// Push, top, size, a pop of zero, and any item that fails or is ignored pass
// from acceptance through the execute state to the output register. A pop
// that removes elements walks the runs it removes or trims, one run per cycle
// on the run memory's single read port, then answers from a response state.
// The result sits in an output register; a new item is accepted while it
// waits, and work on that item holds until the register frees. The first FULL
// or EMPTY latches an error, and every later item answers status 3 until reset.
`default_nettype none
`include "run_length_bounded_stack_top_defines.svh"

module run_length_bounded_stack_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rlbs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rlbs_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);
  import rlbs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rlbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rlbs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

  `RLBS_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "second item taken while busy")
  `RLBS_ASSERT_NXT(a_err_sticky, clk_i, rst_ni, stat.err, stat.err, "error latch cleared")
  `RLBS_ASSERT_IMP(a_data_ok, clk_i, rst_ni, out_valid_o && out_item_o.data_valid, out_item_o.status == ST_OK, "data with bad status")
  `RLBS_ASSERT_IMP(a_data_zero, clk_i, rst_ni, out_valid_o && !out_item_o.data_valid, out_item_o.data_out == '0, "stray data")

endmodule

`default_nettype wire
